/* design/entropy_from_count_stream_defines.svh */
// Assertion macros for the count-stream entropy block.
// Included by the top level; depends on nothing.
`ifndef ENTROPY_FROM_COUNT_STREAM_DEFINES_SVH
`define ENTROPY_FROM_COUNT_STREAM_DEFINES_SVH
`define EFC_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define EFC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`endif

/* design/efc_pkg.sv */
// Package for the count-stream entropy block: types and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package efc_pkg;
    localparam int unsigned ELEM_WIDTH = 33;
    localparam int unsigned SUM_WIDTH  = 64;
    localparam int unsigned MANT_WIDTH = 32;

    typedef struct packed {
        logic [31:0] count;
        logic        last;
        logic        sob;
    } t_in_word;

    typedef struct packed {
        logic [31:0] entropy;
        logic [15:0] dist_index;
        logic        zero_total;
    } t_out_word;
endpackage
`default_nettype wire

/* design/efc_stream_if.sv */
// Valid/ready channel interface carrying one packed word.
// Depends on nothing; the word type is a type parameter.
`timescale 1ns / 1ps
`default_nettype none
interface efc_stream_if #(
    parameter type T = logic [31:0]
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/efc_log2.sv */
// Sequential fixed-point log2: one squaring step per cycle.
// Depends on efc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module efc_log2
    import efc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 26
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [31:0]                      i_x,
    output logic                                  o_busy,
    output logic                                  o_done,
    output logic [5+FRAC_BITS-1:0]                o_log
);
    localparam int unsigned CW = $clog2(FRAC_BITS + 1);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_NORM = 3'b010,
        S_SQR  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [31:0]           r_x;
    logic [4:0]            r_e;
    logic [32:0]           r_m;
    logic [FRAC_BITS-1:0]  r_frac;
    logic [CW-1:0]         r_cnt;
    logic                  r_done;
    logic [4:0]            w_e;
    logic [65:0]           w_sq;
    logic [33:0]           w_m;

    always_comb begin
        w_e = 5'd0;
        for (int i = 1; i < 32; i++) begin
            if (r_x[i]) begin
                w_e = 5'(i);
            end
        end
    end

    assign w_sq = 66'(r_m) * 66'(r_m);
    assign w_m  = w_sq[64:31];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_NORM;
            S_NORM: n_state = (FRAC_BITS == 0) ? S_IDLE : S_SQR;
            S_SQR:  if (r_cnt == CW'(FRAC_BITS - 1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_SQR) && (n_state == S_IDLE);
        end
        case (r_state)
            S_IDLE: begin
                r_x <= i_x;
            end
            S_NORM: begin
                r_e    <= w_e;
                r_m    <= {1'b0, r_x << (5'd31 - w_e)};
                r_frac <= '0;
                r_cnt  <= '0;
            end
            S_SQR: begin
                r_cnt <= r_cnt + CW'(1);
                if (w_m[33:32] != 2'b00) begin
                    r_frac <= {r_frac[FRAC_BITS-2:0], 1'b1};
                    r_m    <= w_m[33:1];
                end else begin
                    r_frac <= {r_frac[FRAC_BITS-2:0], 1'b0};
                    r_m    <= w_m[32:0];
                end
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_log  = {r_e, r_frac};
endmodule
`default_nettype wire

/* design/efc_div.sv */
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on efc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module efc_div
    import efc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [63:0]      o_quot
);
    logic        r_busy, r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [32:0] w_sh;

    assign w_sh = {r_rem[31:0], r_q[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 7'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (!r_busy && i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 7'd1;
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

/* design/efc_front.sv */
// Front end: accepts count words and queues them.
// Depends on efc_pkg and efc_stream_if.
`timescale 1ns / 1ps
`default_nettype none
module efc_front
    import efc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    efc_stream_if.sink   s_in,
    efc_stream_if.source m_q
);
    localparam int unsigned DEPTH = 4;
    t_in_word   r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push, w_pop;

    assign s_in.ready = (r_cnt != 3'(DEPTH));
    assign w_push = s_in.valid && s_in.ready;
    assign w_pop  = m_q.valid && m_q.ready;
    assign m_q.valid = (r_cnt != 3'd0);
    assign m_q.data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(w_push) - 3'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= s_in.data;
    end
endmodule
`default_nettype wire

/* design/efc_back.sv */
// Back end: log2, weighting, accumulation, division and result register.
// Depends on efc_pkg, efc_stream_if, efc_log2 and efc_div.
`timescale 1ns / 1ps
`default_nettype none
module efc_back
    import efc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 26,
    parameter int unsigned INDEX_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    efc_stream_if.sink   s_q,
    efc_stream_if.source m_out
);
    localparam int unsigned LW = 5 + FRAC_BITS;
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOG  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_ACC  = 7'b0001000,
        S_NLOG = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                 r_state;
    logic [31:0]            r_c;
    logic                   r_last;
    logic [31:0]            r_total;
    logic                   r_known;
    logic [ELEM_WIDTH-1:0]  r_elem;
    logic [SUM_WIDTH-1:0]   r_sum;
    logic [INDEX_WIDTH-1:0] r_idx;
    logic [63:0]            r_prod;
    logic [LW-1:0]          r_ln;
    logic                   r_ov;
    t_out_word              r_out;
    logic                   r_ovalid;
    logic                   lg_start, lg_busy, lg_done;
    logic [31:0]            lg_x;
    logic [LW-1:0]          lg_log;
    logic                   dv_start, dv_busy, dv_done;
    logic [63:0]            dv_q;
    logic [31:0]            w_c;
    logic [32:0]            w_tsum;
    logic [32:0]            w_cmax;
    logic [64:0]            w_asum;
    logic [63:0]            w_ent;

    assign w_cmax = (33'd1 << COUNT_WIDTH) - 33'd1;
    assign w_c    = s_q.data.count & w_cmax[31:0];
    assign s_q.ready = (r_state == S_IDLE) && !r_ovalid;
    assign lg_start  = (r_state == S_IDLE && s_q.valid && s_q.ready && w_c > 32'd1)
                     || (r_state == S_MUL && r_last && r_elem != {1'b0, r_total}
                         && r_total != 32'd0);
    assign lg_x = (r_state == S_IDLE) ? w_c : r_total;
    assign dv_start = (r_state == S_NLOG) && lg_done;
    assign w_tsum = {1'b0, r_total} + {1'b0, r_c};
    assign w_asum = {1'b0, r_sum} + {1'b0, r_prod};
    assign w_ent  = (dv_q >= 64'(r_ln)) ? 64'd0 : (64'(r_ln) - dv_q);

    efc_log2 #(.FRAC_BITS(FRAC_BITS)) u_log (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lg_start), .i_x(lg_x),
        .o_busy(lg_busy), .o_done(lg_done), .o_log(lg_log)
    );
    efc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start), .i_num(r_sum),
        .i_den(r_total), .o_busy(dv_busy), .o_done(dv_done), .o_quot(dv_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_known  <= 1'b0;
            r_elem   <= '0;
            r_sum    <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (m_out.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_q.valid && s_q.ready) begin
                        r_c    <= w_c;
                        r_last <= s_q.data.last;
                        r_ov   <= (w_c > 32'd1);
                        if (s_q.data.sob) begin
                            r_total <= '0;
                            r_known <= 1'b0;
                            r_idx   <= '0;
                            r_elem  <= ELEM_WIDTH'(1);
                            r_sum   <= '0;
                        end else if (r_elem != {ELEM_WIDTH{1'b1}}) begin
                            r_elem  <= r_elem + ELEM_WIDTH'(1);
                        end
                        if (s_q.data.sob) begin
                            r_prod <= '0;
                        end
                        r_state <= (w_c > 32'd1) ? S_LOG : S_ACC;
                    end
                end
                S_LOG: if (lg_done) begin
                    r_prod  <= 64'(r_c) * 64'(lg_log);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_ov) r_sum <= w_asum[64] ? {SUM_WIDTH{1'b1}} : w_asum[63:0];
                    if (!r_known) begin
                        r_total <= (w_tsum > w_cmax) ? w_cmax[31:0] : w_tsum[31:0];
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_known <= 1'b1;
                        if (r_elem == {1'b0, r_total}) begin
                            r_idx   <= r_idx + INDEX_WIDTH'(1);
                            r_elem  <= '0;
                            r_sum   <= '0;
                            r_state <= S_IDLE;
                        end else if (r_total == 32'd0) begin
                            r_out.entropy    <= '0;
                            r_out.dist_index <= 16'(r_idx);
                            r_out.zero_total <= 1'b1;
                            r_state          <= S_OUT;
                        end else begin
                            r_state <= S_NLOG;
                        end
                    end
                end
                S_NLOG: begin
                    if (lg_done) begin
                        r_ln    <= lg_log;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (dv_done) begin
                        r_out.entropy    <= w_ent[31:0];
                        r_out.dist_index <= 16'(r_idx);
                        r_out.zero_total <= 1'b0;
                        r_state          <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_idx    <= r_idx + INDEX_WIDTH'(1);
                    r_elem   <= '0;
                    r_sum    <= '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;
endmodule
`default_nettype wire

/* design/entropy_from_count_stream.sv */
// Entropy from count stream: a count above one passes through the back end's log2 (with
// 26 squaring steps), weight and accumulate; any other count skips the log2 and weight.
// A distribution end with a nonzero total that is not pruned adds log2 of N and a 64-step
// divider, plus the result handshake. One word in flight in the back end; a 4-word queue
// decouples input. Throughput set by the shared log2 unit and the divider.
// Reset i_rst_n is synchronous active low and clears totals, index and queues.
`timescale 1ns / 1ps
`default_nettype none
`include "entropy_from_count_stream_defines.svh"
module entropy_from_count_stream
    import efc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 26,
    parameter int unsigned INDEX_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    efc_stream_if.sink   s_in,
    efc_stream_if.source m_out
);
    efc_stream_if #(.T(t_in_word)) q_if ();

    efc_front u_front (.i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in), .m_q(q_if.source));
    efc_back #(
        .COUNT_WIDTH(COUNT_WIDTH), .FRAC_BITS(FRAC_BITS), .INDEX_WIDTH(INDEX_WIDTH)
    ) u_back (.i_clk(i_clk), .i_rst_n(i_rst_n), .s_q(q_if.sink), .m_out(m_out));

    `EFC_ASSERT_NEVER(a_zero_ent, i_clk, i_rst_n,
        m_out.valid && m_out.data.zero_total && m_out.data.entropy != 32'd0,
        "zero total with nonzero entropy")
    `EFC_ASSERT_IMPL(a_q_hold, i_clk, i_rst_n,
        (q_if.valid && !q_if.ready) |=> q_if.valid, "queue word dropped")
endmodule
`default_nettype wire

/* verif/tb_entropy_from_count_stream.sv */
// Self-checking testbench for entropy_from_count_stream: a directed table, then random batches.
// Words are checked against an in-bench entropy predictor.
// Depends on efc_pkg, efc_stream_if and the top level.
`timescale 1ns / 1ps
module tb_entropy_from_count_stream
    import efc_pkg::*;
();

    localparam int unsigned FRAC = 26;
    localparam int unsigned RAND_WORDS = 600;
    localparam int unsigned QUIET_TAIL = 100;
    localparam longint unsigned CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [31:0] count;
        logic        last;
        logic        sob;
        bit          typed;
        t_out_word   res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    efc_stream_if #(.T(t_in_word))  in_if ();
    efc_stream_if #(.T(t_out_word)) out_if ();

    entropy_from_count_stream u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (in_if.sink),
        .m_out  (out_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [63:0] pred_total;
    bit          pred_known;
    logic [63:0] elem_cnt;
    logic [63:0] wlog_sum;
    logic [15:0] dist_idx;

    t_out_word   entropy_q[$];
    t_in_word    words[$];
    bit          typed_q[$];
    t_out_word   typed_res[$];
    int          errors = 0;
    bit          quiet = 0;
    longint unsigned cycles = 0;

    function automatic logic [63:0] log2_fixed(logic [63:0] x);
        int unsigned e;
        logic [63:0] m;
        logic [63:0] fr;
        e = 0;
        fr = 0;
        while (e < 31 && (x >> (e + 1)) != 0) e++;
        m = (x << (31 - e)) & 64'hFFFF_FFFF;
        for (int i = 0; i < FRAC; i++) begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000) begin
                fr = fr | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(e) << FRAC) | fr;
    endfunction

    function automatic void clear_batch();
        pred_total = 0;
        pred_known = 0;
        dist_idx = 0;
        elem_cnt = 0;
        wlog_sum = 0;
    endfunction

    function automatic bit predict_entropy(t_in_word w, output t_out_word r);
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] ln;
        logic [63:0] q;
        bit emit;
        c = 64'(w.count);
        r = '0;
        emit = 0;
        if (w.sob) clear_batch();
        if (elem_cnt < 64'h1_FFFF_FFFF) elem_cnt++;
        if (c > 1) begin
            s = wlog_sum + c * log2_fixed(c);
            wlog_sum = (s < wlog_sum) ? '1 : s;
        end
        if (!pred_known) begin
            s = pred_total + c;
            pred_total = (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
        end
        if (w.last) begin
            pred_known = 1;
            emit = (elem_cnt != pred_total);
            if (emit) begin
                r.dist_index = dist_idx;
                if (pred_total == 0) begin
                    r.zero_total = 1'b1;
                end else begin
                    ln = log2_fixed(pred_total);
                    q = wlog_sum / pred_total;
                    r.entropy = (q >= ln) ? 32'd0 : 32'(ln - q);
                end
            end
            dist_idx++;
            elem_cnt = 0;
            wlog_sum = 0;
        end
        return emit;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void add_word(logic [31:0] c, logic l, logic sb);
        t_in_word w;
        w.count = c;
        w.last = l;
        w.sob = sb;
        words.insert(words.size(), w);
        typed_q.insert(typed_q.size(), 1'b0);
        typed_res.insert(typed_res.size(), t_out_word'('0));
    endfunction

    function automatic logic [31:0] rand_count();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 6) return $urandom_range(0, 4);
        if (k < 8) return $urandom_range(0, 300);
        return $urandom;
    endfunction

    function automatic void build_random();
        int unsigned len;
        int unsigned ndist;
        int unsigned nsum;
        while (words.size() < RAND_WORDS) begin
            if ($urandom_range(0, 9) == 0) begin
                add_word($urandom, 1'($urandom), 1'($urandom));
                continue;
            end
            len = $urandom_range(1, 4);
            nsum = 0;
            for (int i = 0; i < len; i++) begin
                logic [31:0] c;
                c = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 3);
                nsum += (c < 8) ? c : 0;
                add_word(c, i == len - 1, i == 0);
            end
            ndist = $urandom_range(1, 8);
            for (int d = 0; d < ndist; d++) begin
                len = (nsum > 0 && nsum < 12 && $urandom_range(0, 2) == 0) ?
                      nsum : $urandom_range(1, 10);
                for (int i = 0; i < len; i++) add_word(rand_count(), i == len - 1, 1'b0);
            end
        end
    endfunction

    // output side: random stalls, checks sampled at the falling edge
    int unsigned stall_left = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL entropy_from_count_stream");
            $finish;
        end
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0 && !quiet) begin
            stall_left <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 6);
        end
    end

    always @(negedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (entropy_q.size() == 0) begin
                report_mismatch("unexpected word", 64'(got), 64'd0);
            end else begin
                want = entropy_q.pop_front();
                if (got.entropy !== want.entropy)
                    report_mismatch("entropy", 64'(got.entropy), 64'(want.entropy));
                if (got.dist_index !== want.dist_index)
                    report_mismatch("dist_index", 64'(got.dist_index), 64'(want.dist_index));
                if (got.zero_total !== want.zero_total)
                    report_mismatch("zero_total", 64'(got.zero_total), 64'(want.zero_total));
            end
        end
    end

    t_row table_rows[] = '{
        '{32'd0,          1'b1, 1'b1, 1, '{32'd0, 16'd0, 1'b1}},
        '{32'd7,          1'b1, 1'b0, 1, '{32'd0, 16'd1, 1'b1}},
        '{32'd1,          1'b0, 1'b1, 0, '0},
        '{32'd1,          1'b1, 1'b0, 0, '0},
        '{32'hFFFF_FFFF,  1'b1, 1'b0, 1, '{32'd0, 16'd1, 1'b0}},
        '{32'd2,          1'b0, 1'b0, 0, '0},
        '{32'd2,          1'b1, 1'b0, 0, '0},
        '{32'd3,          1'b1, 1'b0, 0, '0},
        '{32'hFFFF_FFFF,  1'b0, 1'b1, 0, '0},
        '{32'hFFFF_FFFF,  1'b1, 1'b0, 0, '0},
        '{32'hFFFF_FFFF,  1'b0, 1'b0, 0, '0},
        '{32'hFFFF_FFFF,  1'b0, 1'b0, 0, '0},
        '{32'hFFFF_FFFF,  1'b1, 1'b0, 0, '0},
        '{32'd1,          1'b1, 1'b0, 0, '0},
        '{32'd0,          1'b0, 1'b1, 0, '0},
        '{32'd1,          1'b1, 1'b0, 1, '{32'd0, 16'd0, 1'b0}},
        '{32'h8000_0000,  1'b1, 1'b0, 0, '0},
        '{32'h5555_5555,  1'b0, 1'b1, 0, '0},
        '{32'hAAAA_AAAA,  1'b1, 1'b0, 0, '0},
        '{32'd5,          1'b0, 1'b0, 0, '0},
        '{32'd1000,       1'b1, 1'b0, 0, '0}
    };

    initial begin
        t_out_word r;
        bit emit;
        in_if.valid = 1'b0;
        in_if.data = '0;
        clear_batch();
        foreach (table_rows[i]) begin
            add_word(table_rows[i].count, table_rows[i].last, table_rows[i].sob);
            typed_q[i] = table_rows[i].typed;
            typed_res[i] = table_rows[i].res;
        end
        build_random();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (words[i]) begin
            if (i + QUIET_TAIL >= words.size()) quiet = 1;
            if (!quiet && $urandom_range(0, 5) == 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            in_if.valid <= 1'b1;
            in_if.data <= words[i];
            do @(negedge i_clk); while (!in_if.ready);
            emit = predict_entropy(words[i], r);
            if (typed_q[i]) begin
                if (!emit) report_mismatch("table row gives no word", 64'(i), 64'd0);
                r = typed_res[i];
                emit = 1;
            end
            if (emit) entropy_q.insert(entropy_q.size(), r);
            @(posedge i_clk);
        end
        in_if.valid <= 1'b0;
        while (entropy_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS entropy_from_count_stream");
        end else begin
            $display("FAIL entropy_from_count_stream");
        end
        $finish;
    end
endmodule

/* entropy_from_count_stream.f */
+incdir+design
design/efc_pkg.sv
design/efc_stream_if.sv
design/efc_log2.sv
design/efc_div.sv
design/efc_front.sv
design/efc_back.sv
design/entropy_from_count_stream.sv
verif/tb_entropy_from_count_stream.sv
